[design/anxb_pkg.sv]
// Shared types and constants for the Annex B NAL unit splitter.
// Used by the front classifier, the item queue, the back end and the top level.
`default_nettype none

package anxb_pkg;

  localparam int unsigned MAX_ZERO_RUN = 65535;
  localparam logic [15:0] RUN_LIMIT =
      16'((MAX_ZERO_RUN < 32'd65535) ? MAX_ZERO_RUN : 32'd65535);
  localparam logic [15:0] START_MIN_ZEROS = 16'd2;
  localparam logic [7:0]  PREFIX_BYTE = 8'h01;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CLS_ZERO  = 2'd0,
    CLS_ONE   = 2'd1,
    CLS_OTHER = 2'd2
  } byte_class_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    byte_class_t cls;
    logic [7:0]  data;
    logic        last;
  } cls_item_t;

  typedef struct packed {
    logic [15:0] zeros_before;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        nal_first;
    logic        nal_end;
    logic        ended_by_prefix;
    logic        no_unit_found;
    logic        run_saturated;
    logic        buffer_done;
  } out_item_t;

endpackage

`default_nettype wire

[design/anxb_front.sv]
// Front end: accepts raw stream bytes and classifies them for the back end.
// Depends on anxb_pkg for the item and class types.
`default_nettype none

module anxb_front (
  input  wire logic              src_valid,
  output logic                   src_ready,
  input  wire anxb_pkg::in_item_t src_item,
  input  wire logic              q_full,
  output logic                   push,
  output anxb_pkg::cls_item_t    push_item
);
  import anxb_pkg::*;

  assign src_ready = !q_full;
  assign push      = src_valid && !q_full;

  always_comb begin
    push_item.data = src_item.data_byte;
    push_item.last = src_item.last_byte;
    if (src_item.data_byte == 8'h00) begin
      push_item.cls = CLS_ZERO;
    end else if (src_item.data_byte == PREFIX_BYTE) begin
      push_item.cls = CLS_ONE;
    end else begin
      push_item.cls = CLS_OTHER;
    end
  end

endmodule

`default_nettype wire

[design/anxb_queue.sv]
// Short queue of classified items between the front and back ends.
// Depends on anxb_pkg for the queue depth and item type.
`default_nettype none

module anxb_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire anxb_pkg::cls_item_t push_item,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output anxb_pkg::cls_item_t    head_item
);
  import anxb_pkg::*;

  cls_item_t              entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]    wr_ptr;
  logic [QUEUE_AW-1:0]    rd_ptr;
  logic [QUEUE_CW-1:0]    count;

  assign full       = count == QUEUE_CW'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + QUEUE_CW'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[design/anxb_back.sv]
// Back end: tracks unit and zero-run state and registers at most one result per item.
// Depends on anxb_pkg for the item types and the run limit.
`default_nettype none

module anxb_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire anxb_pkg::cls_item_t head_item,
  output logic                   pop,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output anxb_pkg::out_item_t    res_item
);
  import anxb_pkg::*;

  logic        inside_unit, inside_unit_next;
  logic [15:0] zero_run, zero_run_next;
  logic        open_pending, open_pending_next;
  logic        saturated_flag, saturated_flag_next;

  logic        emit;
  logic        sat_set;
  logic        sat_cur;
  logic        at_limit;
  logic        start_code;
  logic [15:0] zr_inc;
  out_item_t   res;

  assign pop = head_valid && (!res_valid || res_ready);

  always_comb begin
    res                 = '0;
    emit                = 1'b0;
    sat_set             = 1'b0;
    inside_unit_next    = inside_unit;
    zero_run_next       = zero_run;
    open_pending_next   = open_pending;
    at_limit            = zero_run >= RUN_LIMIT;
    zr_inc              = at_limit ? zero_run : zero_run + 16'd1;
    start_code          = (head_item.cls == CLS_ONE) && (zero_run >= START_MIN_ZEROS);

    if (!inside_unit) begin
      if (head_item.cls == CLS_ZERO) begin
        zero_run_next = zr_inc;
        sat_set       = at_limit;
        if (head_item.last) begin
          res.no_unit_found = 1'b1;
          emit              = 1'b1;
        end
      end else if (head_item.cls == CLS_ONE) begin
        inside_unit_next  = 1'b1;
        open_pending_next = 1'b1;
        zero_run_next     = '0;
        if (head_item.last) begin
          res.nal_first = 1'b1;
          res.nal_end   = 1'b1;
          emit          = 1'b1;
        end
      end else begin
        res.zeros_before  = zero_run;
        res.payload_byte  = head_item.data;
        res.byte_valid    = 1'b1;
        res.nal_first     = 1'b1;
        res.nal_end       = head_item.last;
        zero_run_next     = '0;
        inside_unit_next  = 1'b1;
        open_pending_next = 1'b0;
        emit              = 1'b1;
      end
    end else begin
      if (head_item.cls == CLS_ZERO) begin
        zero_run_next = zr_inc;
        sat_set       = at_limit;
        if (head_item.last) begin
          res.zeros_before = zr_inc;
          res.nal_first    = open_pending;
          res.nal_end      = 1'b1;
          emit             = 1'b1;
        end
      end else if (start_code) begin
        res.nal_first       = open_pending;
        res.nal_end         = 1'b1;
        res.ended_by_prefix = 1'b1;
        zero_run_next       = '0;
        open_pending_next   = 1'b1;
        emit                = 1'b1;
      end else begin
        res.zeros_before  = zero_run;
        res.payload_byte  = head_item.data;
        res.byte_valid    = 1'b1;
        res.nal_first     = open_pending;
        res.nal_end       = head_item.last;
        zero_run_next     = '0;
        open_pending_next = 1'b0;
        emit              = 1'b1;
      end
    end

    sat_cur             = saturated_flag || sat_set;
    res.run_saturated   = sat_cur;
    res.buffer_done     = head_item.last;
    saturated_flag_next = emit ? 1'b0 : sat_cur;

    if (head_item.last) begin
      inside_unit_next    = 1'b0;
      zero_run_next       = '0;
      open_pending_next   = 1'b0;
      saturated_flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res_item <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_unit    <= 1'b0;
      zero_run       <= '0;
      open_pending   <= 1'b0;
      saturated_flag <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (pop) begin
        inside_unit    <= inside_unit_next;
        zero_run       <= zero_run_next;
        open_pending   <= open_pending_next;
        saturated_flag <= saturated_flag_next;
      end
      if (pop && emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_last_clears_state: assert property (@(posedge clk) disable iff (rst)
    pop && head_item.last |=> !inside_unit && zero_run == '0 && !open_pending
                              && !saturated_flag)
    else $error("state not cleared after last byte");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    pop && head_item.last |=> res_valid && res_item.buffer_done)
    else $error("last byte produced no buffer_done result");

  a_prefix_ends_unit: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.ended_by_prefix |-> res_item.nal_end && !res_item.byte_valid)
    else $error("start code result without unit end");

  a_no_unit_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.no_unit_found |-> res_item.buffer_done && !res_item.nal_end
                                            && res_item.zeros_before == '0)
    else $error("malformed no-unit result");

endmodule

`default_nettype wire

[design/annexb_nal_unit_splitter_core.sv]
// Annex B NAL unit splitter, top level.
// Instantiates anxb_front, anxb_queue and anxb_back; types from anxb_pkg.
//
// Usage:
//   src channel (src_valid/src_ready/src_item) takes one stream byte per item,
//   with last_byte set on the final byte of a buffer.
//   res channel (res_valid/res_ready/res_item) returns zero or one result per
//   byte; leading zeros, held zero runs, a leading prefix and the zeros of a
//   start code give no result. The last byte of a buffer always gives one.
//   Path: an accepted byte is written into the queue, and the back end then
//   registers its result from the queue head into the result register.
//   Throughput: one byte per cycle while res_ready is high, set by the back
//   end's update of unit state and zero-run count as it pops each byte.
//   Stall: while res_ready is low the result register holds; the four-entry
//   queue keeps taking bytes until it fills, then src_ready drops.
//   Reset (rst, synchronous): empties the queue, drops any pending result and
//   returns to searching for a leading prefix. No clearing pass is needed.
`default_nettype none

module annexb_nal_unit_splitter_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              src_valid,
  output logic                   src_ready,
  input  wire anxb_pkg::in_item_t src_item,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output anxb_pkg::out_item_t    res_item
);
  import anxb_pkg::*;

  logic      push;
  logic      pop;
  logic      q_full;
  logic      head_valid;
  cls_item_t push_item;
  cls_item_t head_item;

  anxb_front u_front (
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_item  (src_item),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  anxb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  anxb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item)
  );

endmodule

`default_nettype wire

[tb/annexb_nal_split_checker.sv]
// Checker for the Annex B NAL unit splitter: watches both channels, predicts
// each result from the accepted stream bytes and compares field by field.
// Depends on anxb_pkg for the item types and the start-code constants.
`timescale 1ns / 1ps

module annexb_nal_split_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  input  logic                src_ready,
  input  anxb_pkg::in_item_t  src_item,
  input  logic                res_valid,
  input  logic                res_ready,
  input  anxb_pkg::out_item_t res_item,
  output int                  fail_count,
  output int                  outstanding
);
  import anxb_pkg::*;

  bit          in_unit;
  logic [15:0] zero_run;
  bit          open_pend;
  bit          run_sat;

  out_item_t nal_results_q[$];

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

  function automatic void count_held_zero();
    if (zero_run < RUN_LIMIT) begin
      zero_run = zero_run + 16'd1;
    end else begin
      run_sat = 1'b1;
    end
  endfunction

  function automatic bit split_byte(input in_item_t it, output out_item_t r);
    bit         emit;
    logic [7:0] b;
    bit         fin;
    r = '0;
    emit = 1'b0;
    b = it.data_byte;
    fin = it.last_byte;
    if (!in_unit) begin
      if (b == 8'h00) begin
        count_held_zero();
        if (fin) begin
          r.no_unit_found = 1'b1;
          emit = 1'b1;
        end
      end else if (b == PREFIX_BYTE) begin
        in_unit = 1'b1;
        open_pend = 1'b1;
        zero_run = '0;
        if (fin) begin
          r.nal_first = 1'b1;
          r.nal_end = 1'b1;
          emit = 1'b1;
        end
      end else begin
        r.zeros_before = zero_run;
        r.payload_byte = b;
        r.byte_valid = 1'b1;
        r.nal_first = 1'b1;
        r.nal_end = fin;
        zero_run = '0;
        in_unit = 1'b1;
        open_pend = 1'b0;
        emit = 1'b1;
      end
    end else begin
      if (b == 8'h00) begin
        count_held_zero();
        if (fin) begin
          r.zeros_before = zero_run;
          r.nal_first = open_pend;
          r.nal_end = 1'b1;
          emit = 1'b1;
        end
      end else if (b == PREFIX_BYTE && zero_run >= START_MIN_ZEROS) begin
        r.nal_first = open_pend;
        r.nal_end = 1'b1;
        r.ended_by_prefix = 1'b1;
        zero_run = '0;
        open_pend = 1'b1;
        emit = 1'b1;
      end else begin
        r.zeros_before = zero_run;
        r.payload_byte = b;
        r.byte_valid = 1'b1;
        r.nal_first = open_pend;
        r.nal_end = fin;
        zero_run = '0;
        open_pend = 1'b0;
        emit = 1'b1;
      end
    end
    if (emit) begin
      r.run_saturated = run_sat;
      run_sat = 1'b0;
      if (fin) begin
        r.buffer_done = 1'b1;
        in_unit = 1'b0;
        zero_run = '0;
        open_pend = 1'b0;
      end
    end
    return emit;
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst) begin
      in_unit = 1'b0;
      zero_run = '0;
      open_pend = 1'b0;
      run_sat = 1'b0;
      nal_results_q.delete();
    end else begin
      if (res_valid && res_ready) begin
        got = res_item;
        if (nal_results_q.size() == 0) begin
          $error("result item with nothing expected: %h", got);
          fail_count++;
        end else begin
          want = nal_results_q.pop_front();
          check_field("zeros_before", want.zeros_before, got.zeros_before);
          check_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
          check_field("byte_valid", 16'(want.byte_valid), 16'(got.byte_valid));
          check_field("nal_first", 16'(want.nal_first), 16'(got.nal_first));
          check_field("nal_end", 16'(want.nal_end), 16'(got.nal_end));
          check_field("ended_by_prefix", 16'(want.ended_by_prefix),
                      16'(got.ended_by_prefix));
          check_field("no_unit_found", 16'(want.no_unit_found), 16'(got.no_unit_found));
          check_field("run_saturated", 16'(want.run_saturated), 16'(got.run_saturated));
          check_field("buffer_done", 16'(want.buffer_done), 16'(got.buffer_done));
        end
      end
      if (src_valid && src_ready) begin
        if (split_byte(src_item, want)) begin
          nal_results_q.push_back(want);
        end
      end
    end
    outstanding = nal_results_q.size();
  end

endmodule

[tb/tb_annexb_nal_unit_splitter_core.sv]
// Top of the Annex B NAL unit splitter testbench: clock, reset, byte stream
// stimulus with random idling on both channels, and the final verdict.
// Depends on anxb_pkg, annexb_nal_unit_splitter_core and annexb_nal_split_checker.
`timescale 1ns / 1ps

module tb_annexb_nal_unit_splitter_core;
  import anxb_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      src_valid = 1'b0;
  logic      src_ready;
  in_item_t  src_item = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  out_item_t res_item;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int items_sent = 0;
  int src_idle_pct = 38;
  int rcv_idle_pct = 72;

  annexb_nal_unit_splitter_core DUT (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_item  (src_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  annexb_nal_split_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .src_valid   (src_valid),
    .src_ready   (src_ready),
    .src_item    (src_item),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_item    (res_item),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    res_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(negedge clk);
    end
    src_valid <= 1'b1;
    src_item <= '{data_byte: b, last_byte: fin};
    @(posedge clk);
    while (!src_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    int k;
    k = $urandom_range(0, 9);
    if (k < 3) return 8'h00;
    if (k == 3) return PREFIX_BYTE;
    if (k == 4) return 8'h03;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_wellformed_buffer();
    int lead;
    int len;
    int k;
    lead = $urandom_range(0, 3);
    len = $urandom_range(0, 15);
    for (int i = 0; i < lead; i++) send_byte(8'h00, 1'b0);
    if ($urandom_range(0, 4) != 0) send_byte(PREFIX_BYTE, 1'b0);
    for (int i = 0; i < len; i++) begin
      k = $urandom_range(0, 19);
      if (k == 0) begin
        if ($urandom_range(0, 1)) send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(PREFIX_BYTE, 1'b0);
      end else if (k == 1) begin
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h03, 1'b0);
      end else begin
        send_byte(pick_byte(), 1'b0);
      end
    end
    send_byte(pick_byte(), 1'b1);
  endtask

  task automatic run_random(input int target);
    int k;
    int len;
    while (items_sent < target) begin
      k = $urandom_range(0, 9);
      len = $urandom_range(1, 12);
      if (k < 7) begin
        send_wellformed_buffer();
      end else if (k < 9) begin
        for (int i = 1; i < len; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        for (int i = 1; i < len; i++) send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
      end
    end
  endtask

  initial begin
    int drain;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // only zeros, prefix as last byte, single-byte unit
    send_byte(8'h00, 1'b1);
    send_byte(PREFIX_BYTE, 1'b1);
    send_byte(8'hFF, 1'b1);
    // prefix, single zero before 0x01, emulation byte, start code, zero last
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(PREFIX_BYTE, 1'b0);
    send_byte(8'h65, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(PREFIX_BYTE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(PREFIX_BYTE, 1'b0);
    send_byte(8'h00, 1'b1);
    // unit without a prefix after a held zero, start code completed by last byte
    send_byte(8'h00, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(PREFIX_BYTE, 1'b1);

    run_random(200);

    // hold until every expected item has come
    src_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);

    src_idle_pct = 72;
    rcv_idle_pct = 38;
    run_random(380);

    src_idle_pct = 0;
    rcv_idle_pct = 0;
    run_random(560);

    src_valid <= 1'b0;
    drain = 0;
    while (outstanding != 0 && drain < 10000) begin
      @(negedge clk);
      drain++;
    end
    repeat (20) @(negedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
design/anxb_pkg.sv
design/anxb_front.sv
design/anxb_queue.sv
design/anxb_back.sv
design/annexb_nal_unit_splitter_core.sv
tb/annexb_nal_split_checker.sv
tb/tb_annexb_nal_unit_splitter_core.sv
